// ===== rtl/sld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg
// Widths, latencies and shared types for the skew line distance pipeline.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Field widths
    localparam int CW   = 32;   // origin coordinate width, signed Q16.16
    localparam int DW   = 18;   // direction component width, signed Q2.16
    localparam int LW   = 16;   // parallel limit width
    localparam int OW   = 32;   // distance width
    localparam int FRAC = 32;   // shift from Q.48 down to Q.16

    // Intermediate widths
    localparam int D_W    = CW + 1;
    localparam int PR_W   = 2 * DW;
    localparam int C_W    = 2 * DW + 1;
    localparam int CM_W   = 2 * DW;
    localparam int CH_W   = CM_W / 2;
    localparam int CL_W   = CM_W - CH_W;
    localparam int M2_W   = 2 * CM_W + 2;
    localparam int DA_W   = D_W + DW;
    localparam int P_W    = DA_W + 2;
    localparam int PA_W   = P_W + DW;
    localparam int T_W    = PA_W + 1;
    localparam int E_W    = T_W - FRAC;
    localparam int EH_W   = E_W / 2;
    localparam int EL_W   = E_W - EH_W;
    localparam int ES_W   = 2 * E_W + 2;
    localparam int SQ_RAW = (ES_W > M2_W) ? ES_W : M2_W;
    localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
    localparam int R_W    = SQ_W / 2;
    localparam int RM_W   = R_W + 2;
    localparam int CSL    = C_W / 2;
    localparam int CSH_W  = C_W - CSL;
    localparam int DCL_W  = D_W + CSL + 1;
    localparam int DCH_W  = D_W + CSH_W;
    localparam int DC_W   = D_W + C_W;
    localparam int NUM_W  = DC_W + 2;
    localparam int NUMA_W = NUM_W + 1;
    localparam int DV_W   = (NUMA_W > R_W + OW) ? NUMA_W : R_W + OW;

    // Latencies
    localparam int FRONT_LAT = 8;
    localparam int LAT       = FRONT_LAT + R_W + OW + 2;

    typedef struct packed {
        logic             par;
        logic [NUM_W-1:0] num;
    } sld_side_t;

endpackage
`default_nettype wire

// ===== rtl/skew_line_distance_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skew_line_distance_top
// Shortest distance between two 3D lines, fully pipelined.
// ----------------------------------------------------------------------------
// A line pair can be started in every clock cycle; busy is always low. Each
// transaction yields exactly one result, shown for one cycle with done high,
// after it has passed the eight front stages, one stage per root bit of the
// shared square root, one preparation and 32 quotient stages of the divider,
// and the output register. The receiver cannot stall results. The parallel
// limit must only be written while no transaction is in flight.
module skew_line_distance_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [sld_pkg::CW-1:0] first_origin_x,
    input  wire logic signed [sld_pkg::CW-1:0] first_origin_y,
    input  wire logic signed [sld_pkg::CW-1:0] first_origin_z,
    input  wire logic signed [sld_pkg::DW-1:0] first_dir_x,
    input  wire logic signed [sld_pkg::DW-1:0] first_dir_y,
    input  wire logic signed [sld_pkg::DW-1:0] first_dir_z,
    input  wire logic signed [sld_pkg::CW-1:0] second_origin_x,
    input  wire logic signed [sld_pkg::CW-1:0] second_origin_y,
    input  wire logic signed [sld_pkg::CW-1:0] second_origin_z,
    input  wire logic signed [sld_pkg::DW-1:0] second_dir_x,
    input  wire logic signed [sld_pkg::DW-1:0] second_dir_y,
    input  wire logic signed [sld_pkg::DW-1:0] second_dir_z,
    input  wire logic                          limit_we,
    input  wire logic        [sld_pkg::LW-1:0] limit_data,
    output logic                               done,
    output logic             [sld_pkg::OW-1:0] distance,
    output logic                               parallel_flag
);

    logic [sld_pkg::LW-1:0]           limit_reg;
    logic                             accept;

    logic signed [sld_pkg::CW-1:0]    o1 [0:2];
    logic signed [sld_pkg::DW-1:0]    a  [0:2];
    logic signed [sld_pkg::CW-1:0]    o2 [0:2];
    logic signed [sld_pkg::DW-1:0]    b  [0:2];

    logic                             fr_valid;
    logic [sld_pkg::SQ_W-1:0]         fr_op;
    sld_pkg::sld_side_t               fr_side;
    logic                             sq_valid;
    logic [sld_pkg::R_W-1:0]          sq_root;
    sld_pkg::sld_side_t               sq_side;
    logic                             dv_valid;
    logic [sld_pkg::OW-1:0]           dv_dist;
    logic                             dv_par;

    logic                             done_reg;
    logic [sld_pkg::OW-1:0]           distance_reg;
    logic                             par_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign o1[0] = first_origin_x;
    assign o1[1] = first_origin_y;
    assign o1[2] = first_origin_z;
    assign a[0]  = first_dir_x;
    assign a[1]  = first_dir_y;
    assign a[2]  = first_dir_z;
    assign o2[0] = second_origin_x;
    assign o2[1] = second_origin_y;
    assign o2[2] = second_origin_z;
    assign b[0]  = second_dir_x;
    assign b[1]  = second_dir_y;
    assign b[2]  = second_dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (limit_we)
        begin
            limit_reg <= limit_data;
        end
    end

    sld_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .o1        (o1),
        .a         (a),
        .o2        (o2),
        .b         (b),
        .lim       (limit_reg),
        .out_valid (fr_valid),
        .out_op    (fr_op),
        .out_side  (fr_side)
    );

    sld_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_op     (fr_op),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    sld_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_dist  (dv_dist),
        .out_par   (dv_par)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= dv_dist;
        par_reg      <= dv_par;
    end

    assign done          = done_reg;
    assign distance      = distance_reg;
    assign parallel_flag = par_reg;

    // Every accepted transaction comes out exactly once, a fixed time later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(sld_pkg::LAT) done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && rst_n, sld_pkg::LAT))
        else $error("result without a matching transaction");

    a_limit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !limit_we |=> $stable(limit_reg))
        else $error("parallel limit changed without a write");

endmodule
`default_nettype wire

// ===== rtl/sld_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_front
// Eight-stage front end: cross product, squared lengths, dot products and the
// parallel decision, ending in the operand for the shared square root.
// ----------------------------------------------------------------------------
module sld_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic signed [sld_pkg::CW-1:0]   o1 [0:2],
    input  wire logic signed [sld_pkg::DW-1:0]   a  [0:2],
    input  wire logic signed [sld_pkg::CW-1:0]   o2 [0:2],
    input  wire logic signed [sld_pkg::DW-1:0]   b  [0:2],
    input  wire logic        [sld_pkg::LW-1:0]   lim,
    output logic                                 out_valid,
    output logic             [sld_pkg::SQ_W-1:0] out_op,
    output sld_pkg::sld_side_t                   out_side
);

    localparam int DW    = sld_pkg::DW;
    localparam int LW    = sld_pkg::LW;
    localparam int D_W   = sld_pkg::D_W;
    localparam int PR_W  = sld_pkg::PR_W;
    localparam int C_W   = sld_pkg::C_W;
    localparam int CM_W  = sld_pkg::CM_W;
    localparam int CH_W  = sld_pkg::CH_W;
    localparam int CL_W  = sld_pkg::CL_W;
    localparam int M2_W  = sld_pkg::M2_W;
    localparam int DA_W  = sld_pkg::DA_W;
    localparam int P_W   = sld_pkg::P_W;
    localparam int PA_W  = sld_pkg::PA_W;
    localparam int T_W   = sld_pkg::T_W;
    localparam int E_W   = sld_pkg::E_W;
    localparam int EH_W  = sld_pkg::EH_W;
    localparam int EL_W  = sld_pkg::EL_W;
    localparam int ES_W  = sld_pkg::ES_W;
    localparam int SQ_W  = sld_pkg::SQ_W;
    localparam int CSL   = sld_pkg::CSL;
    localparam int DCL_W = sld_pkg::DCL_W;
    localparam int DCH_W = sld_pkg::DCH_W;
    localparam int DC_W  = sld_pkg::DC_W;
    localparam int NUM_W = sld_pkg::NUM_W;
    localparam int FRAC  = sld_pkg::FRAC;
    localparam int LQ_W  = 2 * LW;

    // Valid bits of the eight stages
    logic [7:0] v_reg;
    logic [7:0] v_next;

    // Stage 1
    logic signed [D_W-1:0]  d1_reg [0:2], d1_next [0:2];
    logic signed [DW-1:0]   a1_reg [0:2];
    logic signed [PR_W-1:0] pr1_reg [0:5], pr1_next [0:5];
    logic        [LQ_W-1:0] lq1_reg, lq1_next;
    // Stage 2
    logic signed [C_W-1:0]  c2_reg [0:2], c2_next [0:2];
    logic        [CM_W-1:0] cm2_reg [0:2], cm2_next [0:2];
    logic signed [D_W-1:0]  d2_reg [0:2];
    logic signed [DW-1:0]   a2_reg [0:2];
    logic signed [DA_W-1:0] da2_reg [0:2], da2_next [0:2];
    logic        [LQ_W-1:0] lq2_reg;
    // Stage 3
    logic [2*CH_W-1:0]      hh3_reg [0:2], hh3_next [0:2];
    logic [CH_W+CL_W-1:0]   hl3_reg [0:2], hl3_next [0:2];
    logic [2*CL_W-1:0]      ll3_reg [0:2], ll3_next [0:2];
    logic signed [P_W-1:0]  p3_reg, p3_next;
    logic signed [DCL_W-1:0] dcl3_reg [0:2], dcl3_next [0:2];
    logic signed [DCH_W-1:0] dch3_reg [0:2], dch3_next [0:2];
    logic signed [D_W-1:0]  d3_reg [0:2];
    logic signed [DW-1:0]   a3_reg [0:2];
    logic        [LQ_W-1:0] lq3_reg;
    // Stage 4
    logic        [M2_W-1:0] m24_reg, m24_next;
    logic signed [DC_W-1:0] dc4_reg [0:2], dc4_next [0:2];
    logic signed [PA_W-1:0] pa4_reg [0:2], pa4_next [0:2];
    logic signed [D_W-1:0]  d4_reg [0:2];
    logic        [LQ_W-1:0] lq4_reg;
    // Stage 5
    logic                    par5_reg, par5_next;
    logic signed [NUM_W-1:0] dot5_reg, dot5_next;
    logic signed [T_W-1:0]   t5_reg [0:2], t5_next [0:2];
    logic        [M2_W-1:0]  m25_reg;
    // Stage 6
    logic                    par6_reg;
    logic        [NUM_W-1:0] num6_reg, num6_next;
    logic        [E_W-1:0]   e6_reg [0:2], e6_next [0:2];
    logic        [M2_W-1:0]  m26_reg;
    logic        [T_W-1:0]   at6 [0:2];
    // Stage 7
    logic                    par7_reg;
    logic        [NUM_W-1:0] num7_reg;
    logic [2*EH_W-1:0]       ehh7_reg [0:2], ehh7_next [0:2];
    logic [EH_W+EL_W-1:0]    ehl7_reg [0:2], ehl7_next [0:2];
    logic [2*EL_W-1:0]       ell7_reg [0:2], ell7_next [0:2];
    logic        [M2_W-1:0]  m27_reg;
    // Stage 8
    logic                    par8_reg;
    logic        [NUM_W-1:0] num8_reg;
    logic        [SQ_W-1:0]  op8_reg, op8_next;
    logic        [ES_W-1:0]  es_sum;

    assign v_next = {v_reg[6:0], in_valid};

    always_comb
    begin
        // Stage 1: origin differences, the six direction products, limit squared
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = D_W'(o2[i]) - D_W'(o1[i]);
        end
        pr1_next[0] = a[1] * b[2];
        pr1_next[1] = a[2] * b[1];
        pr1_next[2] = a[2] * b[0];
        pr1_next[3] = a[0] * b[2];
        pr1_next[4] = a[0] * b[1];
        pr1_next[5] = a[1] * b[0];
        lq1_next = LQ_W'(lim) * LQ_W'(lim);

        // Stage 2: cross product, its magnitudes, delta . first_dir terms
        for (int i = 0; i < 3; i++)
        begin
            c2_next[i]  = C_W'(pr1_reg[2*i]) - C_W'(pr1_reg[2*i+1]);
            cm2_next[i] = c2_next[i][C_W-1] ? CM_W'(-c2_next[i]) : CM_W'(c2_next[i]);
            da2_next[i] = DA_W'(d1_reg[i]) * DA_W'(a1_reg[i]);
        end

        // Stage 3: partial products of the squares and of delta . cross, delta . first_dir sum
        for (int i = 0; i < 3; i++)
        begin
            hh3_next[i]  = (2*CH_W)'(cm2_reg[i][CM_W-1:CL_W]) *
                           (2*CH_W)'(cm2_reg[i][CM_W-1:CL_W]);
            hl3_next[i]  = (CH_W+CL_W)'(cm2_reg[i][CM_W-1:CL_W]) *
                           (CH_W+CL_W)'(cm2_reg[i][CL_W-1:0]);
            ll3_next[i]  = (2*CL_W)'(cm2_reg[i][CL_W-1:0]) *
                           (2*CL_W)'(cm2_reg[i][CL_W-1:0]);
            dcl3_next[i] = DCL_W'(d2_reg[i]) *
                           DCL_W'($signed({1'b0, c2_reg[i][CSL-1:0]}));
            dch3_next[i] = DCH_W'(d2_reg[i]) * DCH_W'($signed(c2_reg[i][C_W-1:CSL]));
        end
        p3_next = P_W'(da2_reg[0]) + P_W'(da2_reg[1]) + P_W'(da2_reg[2]);

        // Stage 4: squared cross length, delta . cross terms, projection terms
        m24_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            m24_next = m24_next + (M2_W'(hh3_reg[i]) << (2*CL_W))
                                + (M2_W'(hl3_reg[i]) << (CL_W+1))
                                + M2_W'(ll3_reg[i]);
            dc4_next[i] = (DC_W'(dch3_reg[i]) <<< CSL) + DC_W'(dcl3_reg[i]);
            pa4_next[i] = PA_W'(p3_reg) * PA_W'(a3_reg[i]);
        end

        // Stage 5: parallel test, skew numerator, perpendicular components
        par5_next = m24_reg <= (M2_W'(lq4_reg) << FRAC);
        dot5_next = NUM_W'(dc4_reg[0]) + NUM_W'(dc4_reg[1]) + NUM_W'(dc4_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            t5_next[i] = (T_W'(d4_reg[i]) <<< FRAC) - T_W'(pa4_reg[i]);
        end

        // Stage 6: magnitudes, components rounded half away from zero
        num6_next = dot5_reg[NUM_W-1] ? NUM_W'(-dot5_reg) : NUM_W'(dot5_reg);
        for (int i = 0; i < 3; i++)
        begin
            at6[i]     = t5_reg[i][T_W-1] ? T_W'(-t5_reg[i]) : T_W'(t5_reg[i]);
            e6_next[i] = E_W'((at6[i] + (T_W'(1) << (FRAC-1))) >> FRAC);
        end

        // Stage 7: partial products of the component squares
        for (int i = 0; i < 3; i++)
        begin
            ehh7_next[i] = (2*EH_W)'(e6_reg[i][E_W-1:EL_W]) *
                           (2*EH_W)'(e6_reg[i][E_W-1:EL_W]);
            ehl7_next[i] = (EH_W+EL_W)'(e6_reg[i][E_W-1:EL_W]) *
                           (EH_W+EL_W)'(e6_reg[i][EL_W-1:0]);
            ell7_next[i] = (2*EL_W)'(e6_reg[i][EL_W-1:0]) *
                           (2*EL_W)'(e6_reg[i][EL_W-1:0]);
        end

        // Stage 8: pick the root operand for the branch taken
        es_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            es_sum = es_sum + (ES_W'(ehh7_reg[i]) << (2*EL_W))
                            + (ES_W'(ehl7_reg[i]) << (EL_W+1))
                            + ES_W'(ell7_reg[i]);
        end
        op8_next = par7_reg ? SQ_W'(es_sum) : SQ_W'(m27_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg   <= d1_next;
        a1_reg   <= a;
        pr1_reg  <= pr1_next;
        lq1_reg  <= lq1_next;

        c2_reg   <= c2_next;
        cm2_reg  <= cm2_next;
        d2_reg   <= d1_reg;
        a2_reg   <= a1_reg;
        da2_reg  <= da2_next;
        lq2_reg  <= lq1_reg;

        hh3_reg  <= hh3_next;
        hl3_reg  <= hl3_next;
        ll3_reg  <= ll3_next;
        p3_reg   <= p3_next;
        dcl3_reg <= dcl3_next;
        dch3_reg <= dch3_next;
        d3_reg   <= d2_reg;
        a3_reg   <= a2_reg;
        lq3_reg  <= lq2_reg;

        m24_reg  <= m24_next;
        dc4_reg  <= dc4_next;
        pa4_reg  <= pa4_next;
        d4_reg   <= d3_reg;
        lq4_reg  <= lq3_reg;

        par5_reg <= par5_next;
        dot5_reg <= dot5_next;
        t5_reg   <= t5_next;
        m25_reg  <= m24_reg;

        par6_reg <= par5_reg;
        num6_reg <= num6_next;
        e6_reg   <= e6_next;
        m26_reg  <= m25_reg;

        par7_reg <= par6_reg;
        num7_reg <= num6_reg;
        ehh7_reg <= ehh7_next;
        ehl7_reg <= ehl7_next;
        ell7_reg <= ell7_next;
        m27_reg  <= m26_reg;

        par8_reg <= par7_reg;
        num8_reg <= num7_reg;
        op8_reg  <= op8_next;
    end

    assign out_valid    = v_reg[7];
    assign out_op       = op8_reg;
    assign out_side.par = par8_reg;
    assign out_side.num = num8_reg;

endmodule
`default_nettype wire

// ===== rtl/sld_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sld_sqrt
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [sld_pkg::SQ_W-1:0]  in_op,
    input  wire sld_pkg::sld_side_t        in_side,
    output logic                           out_valid,
    output logic      [sld_pkg::R_W-1:0]   out_root,
    output sld_pkg::sld_side_t             out_side
);

    localparam int SQ_W = sld_pkg::SQ_W;
    localparam int R_W  = sld_pkg::R_W;
    localparam int RM_W = sld_pkg::RM_W;

    logic                      v_reg    [1:R_W];
    logic [RM_W-1:0]           rem_reg  [1:R_W];
    logic [R_W-1:0]            root_reg [1:R_W];
    logic [SQ_W-1:0]           op_reg   [1:R_W];
    sld_pkg::sld_side_t        side_reg [1:R_W];

    for (genvar s = 0; s < R_W; s++)
    begin : g_stage
        logic               v_in;
        logic [RM_W-1:0]    rem_in;
        logic [R_W-1:0]     root_in;
        logic [SQ_W-1:0]    op_in;
        sld_pkg::sld_side_t side_in;
        logic [RM_W-1:0]    rem_cat;
        logic [RM_W-1:0]    trial;
        logic               ge;
        logic [RM_W-1:0]    rem_next;
        logic [R_W-1:0]     root_next;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign op_in   = in_op;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[s];
            assign rem_in  = rem_reg[s];
            assign root_in = root_reg[s];
            assign op_in   = op_reg[s];
            assign side_in = side_reg[s];
        end

        // The partial remainder never reaches its top two bits, so they can be dropped.
        assign rem_cat   = {rem_in[RM_W-3:0], op_in[SQ_W-1 -: 2]};
        assign trial     = {root_in, 2'b01};
        assign ge        = rem_cat >= trial;
        assign rem_next  = ge ? rem_cat - trial : rem_cat;
        assign root_next = {root_in[R_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_next;
            root_reg[s+1] <= root_next;
            op_reg[s+1]   <= op_in << 2;
            side_reg[s+1] <= side_in;
        end
    end

    assign out_valid = v_reg[R_W];
    assign out_root  = root_reg[R_W];
    assign out_side  = side_reg[R_W];

endmodule
`default_nettype wire

// ===== rtl/sld_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_div
// Rounded, saturating skew-branch division |delta . c| / |c|, one quotient
// bit per stage, with the parallel-branch result carried alongside.
// ----------------------------------------------------------------------------
module sld_div
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [sld_pkg::R_W-1:0]  in_root,
    input  wire sld_pkg::sld_side_t       in_side,
    output logic                          out_valid,
    output logic      [sld_pkg::OW-1:0]   out_dist,
    output logic                          out_par
);

    localparam int R_W  = sld_pkg::R_W;
    localparam int OW   = sld_pkg::OW;
    localparam int DV_W = sld_pkg::DV_W;

    logic              v_reg    [0:OW];
    logic [DV_W-1:0]   rem_reg  [0:OW];
    logic [R_W-1:0]    dvs_reg  [0:OW];
    logic [OW-1:0]     q_reg    [0:OW];
    logic              par_reg  [0:OW];
    logic              ovf_reg  [0:OW];
    logic [OW-1:0]     psat_reg [0:OW];

    logic [DV_W-1:0]   numa;
    logic              ovf_next;
    logic [OW-1:0]     psat_next;

    // Half the divisor is added first so that the quotient rounds half up.
    assign numa      = DV_W'(in_side.num) + DV_W'(in_root >> 1);
    assign ovf_next  = numa >= (DV_W'(in_root) << OW);
    assign psat_next = (in_root > R_W'({OW{1'b1}})) ? {OW{1'b1}} : OW'(in_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= numa;
        dvs_reg[0]  <= in_root;
        q_reg[0]    <= '0;
        par_reg[0]  <= in_side.par;
        ovf_reg[0]  <= ovf_next;
        psat_reg[0] <= psat_next;
    end

    for (genvar j = 1; j <= OW; j++)
    begin : g_stage
        logic [DV_W-1:0] sh;
        logic            ge;

        assign sh = DV_W'(dvs_reg[j-1]) << (OW - j);
        assign ge = rem_reg[j-1] >= sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? rem_reg[j-1] - sh : rem_reg[j-1];
            dvs_reg[j]  <= dvs_reg[j-1];
            q_reg[j]    <= {q_reg[j-1][OW-2:0], ge};
            par_reg[j]  <= par_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
            psat_reg[j] <= psat_reg[j-1];
        end
    end

    assign out_valid = v_reg[OW];
    assign out_par   = par_reg[OW];
    assign out_dist  = par_reg[OW] ? psat_reg[OW] :
                       (ovf_reg[OW] ? {OW{1'b1}} : q_reg[OW]);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the skew line distance pipeline against a bit-exact predictor of the
// cross product, parallel test, perpendicular length and skew quotient. Line
// pairs are started with or without random gaps, and each distance and
// parallel flag is compared in order with the expected values. Several
// parallel limits are used, written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW  = sld_pkg::CW;
    localparam int DW  = sld_pkg::DW;
    localparam int LW  = sld_pkg::LW;
    localparam int OW  = sld_pkg::OW;
    localparam int LAT = sld_pkg::LAT;

    localparam int WATCHDOG_LIMIT = 4 * LAT + 2000;

    typedef struct {
        logic signed [CW-1:0] o1 [3];
        logic signed [DW-1:0] a  [3];
        logic signed [CW-1:0] o2 [3];
        logic signed [DW-1:0] b  [3];
    } line_pair_t;

    typedef struct {
        logic [OW-1:0] len;
        logic          par;
    } line_distance_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] o1_x, o1_y, o1_z, o2_x, o2_y, o2_z;
    logic signed [DW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic                 limit_we;
    logic [LW-1:0]        limit_data;
    logic                 done;
    logic [OW-1:0]        distance;
    logic                 parallel_flag;

    line_distance_t expected_distances [$];
    logic [LW-1:0]  limit_copy;
    int             error_count;
    int             stall_cycles;
    bit             gaps_on;

    skew_line_distance_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_origin_x (o1_x),
        .first_origin_y (o1_y),
        .first_origin_z (o1_z),
        .first_dir_x    (a_x),
        .first_dir_y    (a_y),
        .first_dir_z    (a_z),
        .second_origin_x(o2_x),
        .second_origin_y(o2_y),
        .second_origin_z(o2_z),
        .second_dir_x   (b_x),
        .second_dir_y   (b_y),
        .second_dir_z   (b_z),
        .limit_we       (limit_we),
        .limit_data     (limit_data),
        .done           (done),
        .distance       (distance),
        .parallel_flag  (parallel_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] floor_sqrt(logic [127:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if ({64'd0, trial} * {64'd0, trial} <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic line_distance_t predict_distance(line_pair_t lp, logic [LW-1:0] lim);
        logic signed [127:0] d [3];
        logic signed [127:0] a [3];
        logic signed [127:0] c [3];
        logic signed [127:0] proj;
        logic signed [127:0] t;
        logic signed [127:0] num;
        logic [127:0]        mag2;
        logic [127:0]        lim2;
        logic [127:0]        e;
        logic [127:0]        sum;
        logic [127:0]        quot;
        logic [63:0]         root;
        line_distance_t      res;
        longint              ai [3];
        longint              bi [3];
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = 128'(longint'(lp.o2[i]) - longint'(lp.o1[i]));
            ai[i] = longint'(lp.a[i]);
            bi[i] = longint'(lp.b[i]);
            a[i]  = 128'(ai[i]);
        end
        c[0] = 128'(ai[1] * bi[2] - ai[2] * bi[1]);
        c[1] = 128'(ai[2] * bi[0] - ai[0] * bi[2]);
        c[2] = 128'(ai[0] * bi[1] - ai[1] * bi[0]);
        mag2 = '0;
        for (int i = 0; i < 3; i++)
            mag2 += c[i] * c[i];
        lim2 = 128'(lim) << 16;
        lim2 = lim2 * lim2;
        if (mag2 <= lim2)
        begin
            // Remove the component of the origin difference along the first direction.
            proj = '0;
            for (int i = 0; i < 3; i++)
                proj += d[i] * a[i];
            sum = '0;
            for (int i = 0; i < 3; i++)
            begin
                t = (d[i] <<< 32) - proj * a[i];
                if (t < 0)
                    t = -t;
                e = (t + 128'h8000_0000) >> 32;
                sum += e * e;
            end
            root = floor_sqrt(sum);
            res.len = (root > 64'hFFFF_FFFF) ? '1 : root[31:0];
            res.par = 1'b1;
        end
        else
        begin
            root = floor_sqrt(mag2);
            num  = '0;
            for (int i = 0; i < 3; i++)
                num += d[i] * c[i];
            if (num < 0)
                num = -num;
            num  = num + 128'(root >> 1);
            quot = 128'(num) / {64'd0, root};
            res.len = (quot > 128'hFFFF_FFFF) ? '1 : quot[31:0];
            res.par = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Predict on every accepted transaction and check every result strobe.
    always @(posedge clk)
    begin
        line_pair_t     lp;
        line_distance_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                lp.o1[0] = o1_x; lp.o1[1] = o1_y; lp.o1[2] = o1_z;
                lp.a[0]  = a_x;  lp.a[1]  = a_y;  lp.a[2]  = a_z;
                lp.o2[0] = o2_x; lp.o2[1] = o2_y; lp.o2[2] = o2_z;
                lp.b[0]  = b_x;  lp.b[1]  = b_y;  lp.b[2]  = b_z;
                expected_distances.push_back(predict_distance(lp, limit_copy));
            end
            if (limit_we)
                limit_copy = limit_data;
            if (done)
            begin
                if (expected_distances.size() == 0)
                    report_mismatch("unexpected result", 64'(distance), 64'd0);
                else
                begin
                    want = expected_distances.pop_front();
                    if (distance !== want.len)
                        report_mismatch("distance", 64'(distance), 64'(want.len));
                    if (parallel_flag !== want.par)
                        report_mismatch("parallel_flag", 64'(parallel_flag),
                                        64'(want.par));
                end
            end
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles > WATCHDOG_LIMIT)
            begin
                $display("FAIL skew_line_distance_top");
                $finish;
            end
        end
    end

    task automatic send_pair(line_pair_t lp);
        while (gaps_on && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        o1_x <= lp.o1[0]; o1_y <= lp.o1[1]; o1_z <= lp.o1[2];
        a_x  <= lp.a[0];  a_y  <= lp.a[1];  a_z  <= lp.a[2];
        o2_x <= lp.o2[0]; o2_y <= lp.o2[1]; o2_z <= lp.o2[2];
        b_x  <= lp.b[0];  b_y  <= lp.b[1];  b_z  <= lp.b[2];
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (expected_distances.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [LW-1:0] value);
        drain_pipeline();
        limit_we   <= 1'b1;
        limit_data <= value;
        @(posedge clk);
        limit_we   <= 1'b0;
    endtask

    function automatic line_pair_t make_pair(longint o1x, longint o1y, longint o1z,
                                             longint ax, longint ay, longint az,
                                             longint o2x, longint o2y, longint o2z,
                                             longint bx, longint by, longint bz);
        line_pair_t lp;
        lp.o1[0] = CW'(o1x); lp.o1[1] = CW'(o1y); lp.o1[2] = CW'(o1z);
        lp.a[0]  = DW'(ax);  lp.a[1]  = DW'(ay);  lp.a[2]  = DW'(az);
        lp.o2[0] = CW'(o2x); lp.o2[1] = CW'(o2y); lp.o2[2] = CW'(o2z);
        lp.b[0]  = DW'(bx);  lp.b[1]  = DW'(by);  lp.b[2]  = DW'(bz);
        return lp;
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 2000000))) - 1000000;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
        endcase
    endfunction

    function automatic logic signed [DW-1:0] random_dir();
        case ($urandom_range(4))
            0:       return 18'($urandom);
            1:       return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
            2:       return $urandom_range(1) ? 18'h1FFFF : 18'h20000;
            3:       return '0;
            default: return DW'($signed(18'($urandom_range(0, 131072))) - 65536);
        endcase
    endfunction

    // Mostly general pairs, a share of exactly and nearly parallel directions.
    function automatic line_pair_t random_pair();
        line_pair_t lp;
        int         kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 3; i++)
        begin
            lp.o1[i] = random_coord();
            lp.o2[i] = random_coord();
            lp.a[i]  = random_dir();
            lp.b[i]  = random_dir();
        end
        if (kind >= 6)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (kind == 6)
                    lp.b[i] = lp.a[i];
                else if (kind == 7)
                    lp.b[i] = -lp.a[i];
                else
                    lp.b[i] = DW'(lp.a[i] + $signed(18'($urandom_range(0, 64))) - 32);
            end
        end
        return lp;
    endfunction

    task automatic test_directed_cases();
        line_pair_t lp [$];
        lp.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        lp.push_back(make_pair(-2147483648, -2147483648, -2147483648, 0, 0, 0,
                               2147483647, 2147483647, 2147483647, 0, 0, 0));
        lp.push_back(make_pair(100, -200, 300, 131071, 131071, 131071,
                               -5000, 7000, 9, 131071, 131071, 131071));
        lp.push_back(make_pair(2147483647, 0, -2147483648, -131072, -131072, -131072,
                               -2147483648, 1, 2147483647, 131071, 131071, 131071));
        lp.push_back(make_pair(0, 0, 0, 65536, 0, 0, 0, 0, 655360, 0, 65536, 0));
        lp.push_back(make_pair(0, 0, -2147483648, 1, 0, 0, 0, 0, 2147483647, 0, 1, 0));
        lp.push_back(make_pair(10, 20, 30, 65536, 0, 0, 99999, 131072, 30, 65536, 0, 0));
        lp.push_back(make_pair(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 1, 0));
        lp.push_back(make_pair(2147483647, -2147483648, 12345, 131071, -131072, 5,
                               -2147483648, 2147483647, -12345, -131072, 131071, -7));
        lp.push_back(make_pair(0, 0, 0, 131071, 0, 0, 65536, 65536, 0, 131071, 0, 0));
        lp.push_back(make_pair(-1, -1, -1, -65536, 0, 0, 1, 1, 1, 0, 0, -65536));
        foreach (lp[i])
            send_pair(lp[i]);
        // The same pairs again with the widest limit, so near misses turn parallel.
        write_limit('1);
        foreach (lp[i])
            send_pair(lp[i]);
    endtask

    task automatic test_random_pairs(logic [LW-1:0] lim, int count, bit gaps);
        write_limit(lim);
        gaps_on = gaps;
        repeat (count)
            send_pair(random_pair());
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        limit_we    = 1'b0;
        limit_data  = '0;
        o1_x = '0; o1_y = '0; o1_z = '0; o2_x = '0; o2_y = '0; o2_z = '0;
        a_x  = '0; a_y  = '0; a_z  = '0; b_x  = '0; b_y  = '0; b_z  = '0;
        limit_copy   = '0;
        error_count  = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        write_limit('0);
        test_random_pairs('0, 120, 1'b1);
        test_random_pairs('1, 120, 1'b0);
        test_random_pairs(LW'($urandom), 120, 1'b1);
        test_random_pairs(16'd300, 120, 1'b1);
        test_random_pairs(16'd1, 120, 1'b1);

        drain_pipeline();
        repeat (LAT + 10) @(posedge clk);
        if (error_count == 0)
            $display("PASS skew_line_distance_top");
        else
            $display("FAIL skew_line_distance_top");
        $finish;
    end

endmodule
